// ===== rtl/mm2_pkg.sv =====
// Shared types and constants for the MurmurHash2 string hash block.
package mm2_pkg;

	localparam logic [31:0] HASH_M      = 32'h5bd1_e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned LENGTH_W = 31;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned TDATA_W  = ((LENGTH_W + WORD_W + COUNT_W + 7) / 8) * 8;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

	// Item kind carried on tuser
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	// Operation handed from the front end to the back end
	typedef enum logic [1:0] {
		OP_START,
		OP_FULL,
		OP_PART,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        last;
		logic [31:0] operand;
	} entry_t;

endpackage

// ===== rtl/mm2_front.sv =====
// Front end: accept items, track the open message, classify and premix words.
module mm2_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_kind,
	input  logic [mm2_pkg::LENGTH_W-1:0]  in_length,
	input  logic [mm2_pkg::WORD_W-1:0]    in_word,
	input  logic [mm2_pkg::COUNT_W-1:0]   in_count,
	input  logic                          in_last,
	output logic                          push,
	output mm2_pkg::entry_t               push_entry,
	input  logic                          queue_full
);

	logic                  open_q;
	logic                  valid_s1;
	mm2_pkg::op_t          op_s1;
	logic                  last_s1;
	logic [31:0]           operand_s1;
	logic                  valid_s2;
	mm2_pkg::entry_t       entry_s2;

	logic                  ready_s1;
	logic                  ready_s2;
	logic                  accept;
	logic                  keep;
	mm2_pkg::op_t          op_in;
	logic                  last_in;
	logic [31:0]           operand_in;
	logic [31:0]           mask_in;
	logic [31:0]           k_shift;
	logic [31:0]           operand_mix;

	assign ready_s2 = !valid_s2 || !queue_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign accept   = in_valid && ready_s1;

	// Data arriving with no open message is dropped here
	assign keep = (in_kind == mm2_pkg::KIND_START) || open_q;

	always_comb begin
		unique case (in_count)
			3'd1:    mask_in = 32'h0000_00ff;
			3'd2:    mask_in = 32'h0000_ffff;
			3'd3:    mask_in = 32'h00ff_ffff;
			default: mask_in = 32'hffff_ffff;
		endcase
	end

	always_comb begin
		if (in_kind == mm2_pkg::KIND_START) begin
			op_in      = mm2_pkg::OP_START;
			last_in    = (in_length == '0);
			operand_in = {1'b0, in_length};
		end else begin
			last_in = in_last;
			unique case (in_count)
				3'd0: begin
					op_in      = mm2_pkg::OP_SKIP;
					operand_in = '0;
				end
				3'd1, 3'd2, 3'd3: begin
					op_in      = mm2_pkg::OP_PART;
					operand_in = in_word & mask_in;
				end
				default: begin
					op_in      = mm2_pkg::OP_FULL;
					operand_in = in_word * mm2_pkg::HASH_M;
				end
			endcase
		end
	end

	// Second half of the word mix: fold the high byte down, multiply again
	assign k_shift     = operand_s1 >> mm2_pkg::MIX_SHIFT;
	assign operand_mix = (op_s1 == mm2_pkg::OP_FULL) ?
		(operand_s1 ^ k_shift) * mm2_pkg::HASH_M : operand_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				if (in_kind == mm2_pkg::KIND_START) begin
					open_q <= (in_length != '0);
				end else if (open_q && in_last) begin
					open_q <= 1'b0;
				end
			end
			if (ready_s1) begin
				valid_s1 <= accept && keep;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			op_s1      <= op_in;
			last_s1    <= last_in;
			operand_s1 <= operand_in;
		end
		if (ready_s2) begin
			entry_s2.op      <= op_s1;
			entry_s2.last    <= last_s1;
			entry_s2.operand <= operand_mix;
		end
	end

	assign push       = valid_s2 && !queue_full;
	assign push_entry = entry_s2;

endmodule

// ===== rtl/mm2_queue.sv =====
// Short show-ahead queue between the front end and the back end.
module mm2_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mm2_pkg::entry_t     push_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output mm2_pkg::entry_t     head
);

	mm2_pkg::entry_t                    slots_q [mm2_pkg::QUEUE_DEPTH];
	logic [mm2_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [mm2_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [mm2_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign full      = (count_q == mm2_pkg::QUEUE_CNT_W'(mm2_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

// ===== rtl/mm2_back.sv =====
// Back end: fold queued operations into the running hash and finish messages.
module mm2_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  mm2_pkg::entry_t     head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_hash
);

	logic [31:0]  running_hash_q;
	logic         fin_valid_s1;
	logic [31:0]  fin_hash_s1;
	logic         fin_valid_s2;
	logic [31:0]  fin_prod_s2;
	logic         out_valid_q;
	logic [31:0]  out_hash_q;

	logic         fin_free;
	logic [31:0]  hash_next;
	logic [31:0]  fin_shift_a;
	logic [31:0]  fin_shift_b;

	// A finishing item needs the whole finish pipe and the output slot
	assign fin_free = !fin_valid_s1 && !fin_valid_s2 && (!out_valid_q || out_ready);
	assign pop      = not_empty && (!head.last || fin_free);

	always_comb begin
		unique case (head.op)
			mm2_pkg::OP_START: hash_next = head.operand;
			mm2_pkg::OP_FULL:  hash_next = (running_hash_q * mm2_pkg::HASH_M) ^ head.operand;
			mm2_pkg::OP_PART:  hash_next = (running_hash_q ^ head.operand) * mm2_pkg::HASH_M;
			default:           hash_next = running_hash_q;
		endcase
	end

	assign fin_shift_a = fin_hash_s1 >> mm2_pkg::FIN_SHIFT_A;
	assign fin_shift_b = fin_prod_s2 >> mm2_pkg::FIN_SHIFT_B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
			fin_valid_s1   <= 1'b0;
			fin_valid_s2   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				running_hash_q <= hash_next;
			end
			fin_valid_s1 <= pop && head.last;
			fin_valid_s2 <= fin_valid_s1;
			if (fin_valid_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			fin_hash_s1 <= hash_next;
		end
		if (fin_valid_s1) begin
			fin_prod_s2 <= (fin_hash_s1 ^ fin_shift_a) * mm2_pkg::HASH_M;
		end
		if (fin_valid_s2) begin
			out_hash_q <= fin_prod_s2 ^ fin_shift_b;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hash  = out_hash_q;

	a_single_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({fin_valid_s1, fin_valid_s2}) <= 1)
		else $error("two messages in the finish pipe");

	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_s2 |-> !out_valid_q || out_ready)
		else $error("finished hash would overwrite a pending result");

endmodule

// ===== rtl/murmur2_string_hash.sv =====
// Top level of the MurmurHash2 (32-bit) string hash stream block.
// Path: the result of a message shows on m_axis_tvalid once its last item has passed
//   the 2 front stages, the queue, the back mix and the 2 finish stages.
// Throughput: one item per cycle for words that do not end a message, while the queue
//   has room; a message end waits until the 2-stage finish pipe is empty.
// Reset: arst_n clears the running hash to zero, closes any open message, empties the
//   queue and drops a pending result.
module murmur2_string_hash (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [30:0] message_length, [62:31] data_word, [65:63] byte_count, [71:66] zero
	input  logic [mm2_pkg::TDATA_W-1:0]   s_axis_tdata,
	// [0] kind: 0 starts a message, 1 carries a data word
	input  logic                          s_axis_tuser,
	// last_word
	input  logic                          s_axis_tlast,

	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] hash_value
	output logic [31:0]                   m_axis_tdata
);

	localparam int unsigned LEN_LO   = 0;
	localparam int unsigned WORD_LO  = LEN_LO + mm2_pkg::LENGTH_W;
	localparam int unsigned COUNT_LO = WORD_LO + mm2_pkg::WORD_W;

	logic                                 push;
	mm2_pkg::entry_t                      push_entry;
	logic                                 queue_full;
	logic                                 pop;
	logic                                 queue_not_empty;
	mm2_pkg::entry_t                      queue_head;

	// Front end: drop data outside a message, mask partial words, premix full words
	mm2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_length  (s_axis_tdata[LEN_LO +: mm2_pkg::LENGTH_W]),
		.in_word    (s_axis_tdata[WORD_LO +: mm2_pkg::WORD_W]),
		.in_count   (s_axis_tdata[COUNT_LO +: mm2_pkg::COUNT_W]),
		.in_last    (s_axis_tlast),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	// Decouple the two halves so a stalled result does not stop intake at once
	mm2_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (queue_not_empty),
		.head       (queue_head)
	);

	// Back end: at most one multiply per pop, then the finish mix into the output register
	mm2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (queue_not_empty),
		.head       (queue_head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_hash   (m_axis_tdata)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the MurmurHash2 string hash block.
module tb_top;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int PRINT_LIMIT   = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [30:0] message_length, [62:31] data_word, [65:63] byte_count, [71:66] zero
	logic [mm2_pkg::TDATA_W-1:0] s_axis_tdata = '0;
	// [0] kind
	logic                  s_axis_tuser = 1'b0;
	// last_word
	logic                  s_axis_tlast = 1'b0;

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [31:0] hash_value
	logic [31:0]           m_axis_tdata;

	// Predicted block state and the hashes still owed by the block
	logic [31:0]           hash_state = '0;
	logic                  msg_open = 1'b0;
	logic [31:0]           hash_expect[$];

	int                    mismatch_count = 0;
	int                    items_sent = 0;
	int                    cycle_count = 0;
	int                    gap_pct = 30;
	bit                    calm = 1'b0;

	murmur2_string_hash dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s got %08h want %08h", $realtime, what, got, want);
	endtask

	// Closing avalanche of the hash
	function automatic logic [31:0] finish_mix(input logic [31:0] h);
		h = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
		h = h * mm2_pkg::HASH_M;
		h = h ^ (h >> mm2_pkg::FIN_SHIFT_B);
		return h;
	endfunction

	// Advance the predicted state by one accepted transfer
	task automatic predict_hash(input logic kind, input logic [30:0] len,
		input logic [31:0] word, input logic [2:0] cnt, input logic last);
		logic [31:0] k;
		logic [31:0] mask;
		if (kind == mm2_pkg::KIND_START) begin
			hash_state = {1'b0, len};
			if (len == '0) begin
				msg_open = 1'b0;
				hash_expect.push_back(finish_mix(hash_state));
			end else begin
				msg_open = 1'b1;
			end
		end else if (msg_open) begin
			if (cnt >= 3'd4) begin
				// counts of four to seven take the full-word path
				k = word * mm2_pkg::HASH_M;
				k = k ^ (k >> mm2_pkg::MIX_SHIFT);
				k = k * mm2_pkg::HASH_M;
				hash_state = (hash_state * mm2_pkg::HASH_M) ^ k;
			end else if (cnt != 3'd0) begin
				mask = (32'd1 << (8 * cnt)) - 32'd1;
				hash_state = (hash_state ^ (word & mask)) * mm2_pkg::HASH_M;
			end
			if (last) begin
				msg_open = 1'b0;
				hash_expect.push_back(finish_mix(hash_state));
			end
		end
	endtask

	// Present one item and hold it until the transfer; starts and ends at a rising edge
	task automatic send_item(input logic kind, input logic [30:0] len,
		input logic [31:0] word, input logic [2:0] cnt, input logic last);
		bit hit;
		if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= mm2_pkg::TDATA_W'({cnt, word, len});
		s_axis_tuser  <= kind;
		s_axis_tlast  <= last;
		do begin
			// sample mid-cycle, where every signal is settled
			@(negedge clk);
			hit = s_axis_tready;
			@(posedge clk);
		end while (!hit);
		predict_hash(kind, len, word, cnt, last);
		items_sent++;
	endtask

	// Start a message and feed it word by word; leave it open when close is clear
	task automatic send_message(input logic [30:0] len, input int words, input bit close);
		int tail;
		logic [2:0] cnt;
		send_item(mm2_pkg::KIND_START, len, $urandom, 3'($urandom_range(0, 7)), 1'($urandom));
		tail = int'(len[1:0]);
		for (int i = 0; i < words; i++) begin
			cnt = (i == words - 1 && tail != 0) ? 3'(tail) : 3'd4;
			send_item(mm2_pkg::KIND_DATA, 31'($urandom), $urandom, cnt,
				close && i == words - 1);
		end
	endtask

	// Compare each result transfer with the oldest owed hash
	always @(negedge clk) begin : result_check
		logic [31:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hash_expect.size() == 0) begin
				report_mismatch("unexpected hash_value", m_axis_tdata, '0);
			end else begin
				want = hash_expect.pop_front();
				if (m_axis_tdata !== want)
					report_mismatch("hash_value", m_axis_tdata, want);
			end
		end
	end

	// Receiver pacing: ready runs broken by stall bursts, always ready once calm
	initial begin : rx_pacing
		int run;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
				m_axis_tready <= 1'b1;
				repeat (run) @(posedge clk);
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	task automatic test_zero_length();
		send_item(mm2_pkg::KIND_START, '0, 32'hffff_ffff, 3'd7, 1'b1);
	endtask

	task automatic test_full_words();
		send_item(mm2_pkg::KIND_START, 31'd8, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hffff_ffff, 3'd4, 1'b0);
		send_item(mm2_pkg::KIND_DATA, 31'h7fff_ffff, 32'h0000_0000, 3'd4, 1'b1);
	endtask

	task automatic test_partial_tails();
		// upper bytes of each tail are set and must be masked off
		send_item(mm2_pkg::KIND_START, 31'd5, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h6463_6261, 3'd4, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hffff_ff65, 3'd1, 1'b1);
		send_item(mm2_pkg::KIND_START, 31'd7, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h1234_5678, 3'd4, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hffff_ffff, 3'd3, 1'b1);
		send_item(mm2_pkg::KIND_START, 31'h7fff_ffff, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hdead_beef, 3'd2, 1'b1);
	endtask

	task automatic test_byte_count_edges();
		// partial word not marked last, then an empty last word
		send_item(mm2_pkg::KIND_START, 31'd4, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h8000_00a5, 3'd2, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hffff_ffff, 3'd0, 1'b1);
		// oversized counts hash as full words
		send_item(mm2_pkg::KIND_START, 31'd4, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h0102_0304, 3'd7, 1'b1);
		send_item(mm2_pkg::KIND_START, 31'd8, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'hcafe_f00d, 3'd5, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h5555_aaaa, 3'd6, 1'b1);
	endtask

	task automatic test_stray_data();
		send_item(mm2_pkg::KIND_DATA, '0, 32'h0bad_0bad, 3'd4, 1'b1);
	endtask

	task automatic test_restart();
		// drop the first message and hash only the second
		send_item(mm2_pkg::KIND_START, 31'd12, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h1111_1111, 3'd4, 1'b0);
		send_item(mm2_pkg::KIND_START, 31'd4, '0, '0, 1'b0);
		send_item(mm2_pkg::KIND_DATA, '0, 32'h2222_2222, 3'd4, 1'b1);
	endtask

	task automatic test_random_messages();
		int pick;
		int len;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
			pick = $urandom_range(0, 99);
			len  = $urandom_range(1, 40);
			if (pick < 10)
				send_item(1'($urandom), 31'($urandom), $urandom, 3'($urandom_range(0, 7)),
					1'($urandom));
			else if (pick < 15)
				send_message('0, 0, 1'b1);
			else if (pick < 19)
				send_message(31'($urandom), $urandom_range(1, 6), 1'b1);
			else if (pick < 24)
				send_message(31'(len), $urandom_range(0, (len + 3) / 4), 1'b0);
			else
				send_message(31'(len), (len + 3) / 4, 1'b1);
		end
	endtask

	task automatic test_back_to_back();
		int len;
		calm = 1'b1;
		repeat (25) begin
			len = $urandom_range(0, 16);
			send_message(31'(len), (len + 3) / 4, 1'b1);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_length();
		test_full_words();
		test_partial_tails();
		test_byte_count_edges();
		test_stray_data();
		test_restart();
		test_random_messages();
		test_back_to_back();

		s_axis_tvalid <= 1'b0;
		while (hash_expect.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mm2_pkg.sv
rtl/mm2_front.sv
rtl/mm2_queue.sv
rtl/mm2_back.sv
rtl/murmur2_string_hash.sv
sim/tb_top.sv
